/* sv/bucket_lock_table_assert.svh */
// Assertion macros for the bucket lock table
`ifndef BUCKET_LOCK_TABLE_ASSERT_SVH
`define BUCKET_LOCK_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked every cycle outside reset
`define BLT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("bucket_lock_table: assertion failed");
// Implication from a trigger to a consequent in the next cycle
`define BLT_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("bucket_lock_table: assertion failed");
`else
`define BLT_ASSERT(lbl, prop)
`define BLT_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

/* sv/bkt_lock_pkg.sv */
// Shared types and constants for the bucket lock table
package bkt_lock_pkg;

    localparam int MAX_HOLDERS_DEF = 16;
    localparam int ID_BITS_DEF     = 10;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNHELD   = 3'd4;

    // Per-cell control strobes
    typedef struct packed {
        logic cmp;    // compare the incoming id, latch match
        logic load;   // write the held id into this cell
        logic shift;  // take the neighbor's entry (compaction)
    } cell_ctl_t;

endpackage

/* sv/bkt_lock_cell.sv */
// One table cell: holds one id, compares it, and shifts down on release
module bkt_lock_cell #(
    parameter int ID_BITS = bkt_lock_pkg::ID_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bkt_lock_pkg::cell_ctl_t ctl,
    input  logic                   live,
    input  logic [ID_BITS-1:0]     cmp_key,
    input  logic [ID_BITS-1:0]     load_key,
    input  logic [ID_BITS-1:0]     entry_up,
    input  logic                   seen_in,
    output logic [ID_BITS-1:0]     entry_out,
    output logic                   seen_out,
    output logic                   match_out
);

    logic [ID_BITS-1:0] entry_reg;
    logic               match_reg;

    // Entry storage: load on grant, take upper neighbor on release
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            entry_reg <= load_key;
        end else if (ctl.shift) begin
            entry_reg <= entry_up;
        end
    end

    // Match flag captured when the request beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctl.cmp) begin
            match_reg <= live && (entry_reg == cmp_key);
        end
    end

    assign entry_out = entry_reg;
    assign match_out = match_reg;
    // Running "match at or below" flag along the chain
    assign seen_out  = seen_in | match_reg;

endmodule

/* sv/bucket_lock_table.sv */
// Bucket lock table: each request is taken in an accept state and resolved in an update state.
// The accept cycle compares the id against all cells in parallel and registers the match; the update
// state, once the result register is free, resolves status, appends or compacts the chain, and loads the result.
// A new request is not taken until the current one has loaded its result.
// Reset (aresetn, synchronous, active low) empties the table; entries are
// not cleared, only the held count.
module bucket_lock_table #(
    parameter int MAX_HOLDERS = bkt_lock_pkg::MAX_HOLDERS_DEF,
    parameter int ID_BITS     = bkt_lock_pkg::ID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [ID_BITS-1:0]                s_bucket_id,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bkt_lock_pkg::STATUS_W-1:0] m_status,
    output logic [bkt_lock_pkg::COUNT_W-1:0]  m_held_count
);

    localparam int CNT_W = $clog2(MAX_HOLDERS + 1);
    localparam int EXT_W = CNT_W + bkt_lock_pkg::COUNT_W;

    typedef enum logic {S_IDLE, S_UPD} state_t;

    state_t                            st_reg;
    logic                              mode_reg;
    logic [ID_BITS-1:0]                key_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              m_valid_reg;
    logic [bkt_lock_pkg::STATUS_W-1:0] status_reg;
    logic [bkt_lock_pkg::STATUS_W-1:0] status_next;
    logic [bkt_lock_pkg::COUNT_W-1:0]  held_count_reg;
    logic [EXT_W-1:0]                  count_ext;

    logic [ID_BITS-1:0]     entry  [MAX_HOLDERS];
    logic [MAX_HOLDERS:0]   seen;
    logic [MAX_HOLDERS-1:0] match;

    logic accept, upd_go, full, hit, grant, rel_ok;

    assign accept = s_valid && s_ready;
    assign upd_go = (st_reg == S_UPD) && (!m_valid_reg || m_ready);
    assign full   = (count_reg == CNT_W'(MAX_HOLDERS));
    assign hit    = seen[MAX_HOLDERS];
    assign grant  = !mode_reg && !full && !hit;
    assign rel_ok = mode_reg && hit;
    assign seen[0] = 1'b0;

    // Chain of cells
    for (genvar i = 0; i < MAX_HOLDERS; i++) begin : g_cell
        bkt_lock_pkg::cell_ctl_t ctl;
        logic [ID_BITS-1:0]      up;

        assign ctl.cmp   = accept;
        assign ctl.load  = upd_go && grant && (count_reg == CNT_W'(i));
        assign ctl.shift = upd_go && rel_ok && seen[i+1];

        if (i == MAX_HOLDERS - 1) begin : g_top
            assign up = entry[i];
        end else begin : g_mid
            assign up = entry[i+1];
        end

        bkt_lock_cell #(.ID_BITS(ID_BITS)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .live      (CNT_W'(i) < count_reg),
            .cmp_key   (s_bucket_id),
            .load_key  (key_reg),
            .entry_up  (up),
            .seen_in   (seen[i]),
            .entry_out (entry[i]),
            .seen_out  (seen[i+1]),
            .match_out (match[i])
        );
    end

    // Status and count resolution
    always_comb begin
        count_next  = count_reg;
        status_next = bkt_lock_pkg::ST_GRANTED;
        if (!mode_reg) begin
            if (full) begin
                status_next = bkt_lock_pkg::ST_FULL;
            end else if (hit) begin
                status_next = bkt_lock_pkg::ST_BUSY;
            end else begin
                status_next = bkt_lock_pkg::ST_GRANTED;
                count_next  = count_reg + CNT_W'(1);
            end
        end else begin
            if (hit) begin
                status_next = bkt_lock_pkg::ST_RELEASED;
                count_next  = count_reg - CNT_W'(1);
            end else begin
                status_next = bkt_lock_pkg::ST_UNHELD;
            end
        end
    end

    // Held count reported modulo the output width
    assign count_ext = {{bkt_lock_pkg::COUNT_W{1'b0}}, count_next};

    // Control FSM and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Result valid: set on update, cleared once the beat is taken
            if (upd_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (accept) begin
                        mode_reg <= s_mode;
                        key_reg  <= s_bucket_id;
                        st_reg   <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_go) begin
                        count_reg      <= count_next;
                        status_reg     <= status_next;
                        held_count_reg <= count_ext[bkt_lock_pkg::COUNT_W-1:0];
                        st_reg         <= S_IDLE;
                    end
                end
                default: begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (st_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_held_count = held_count_reg;

`include "bucket_lock_table_assert.svh"

    `BLT_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_HOLDERS))
    `BLT_ASSERT(a_single_match, (st_reg != S_UPD) || $onehot0(match))
    `BLT_ASSERT_NEXT(a_grant_grows, upd_go && grant, count_reg == $past(count_reg) + CNT_W'(1))
    `BLT_ASSERT_NEXT(a_release_shrinks, upd_go && rel_ok, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

/* bench/bucket_lock_table_chk.sv */
// Checker for the bucket lock table: mirrors the held-id list and compares every result beat
`timescale 1ns / 100ps
module bucket_lock_table_chk #(
    parameter int MAX_HOLDERS = bkt_lock_pkg::MAX_HOLDERS_DEF,
    parameter int ID_BITS     = bkt_lock_pkg::ID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_mode,
    input  logic [ID_BITS-1:0]                s_bucket_id,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [bkt_lock_pkg::STATUS_W-1:0] m_status,
    input  logic [bkt_lock_pkg::COUNT_W-1:0]  m_held_count,
    output int                                fail_count,
    output int                                pending
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [bkt_lock_pkg::STATUS_W-1:0] status;
        logic [bkt_lock_pkg::COUNT_W-1:0]  held_count;
    } lock_result_t;

    // Shadow copy of the table
    logic [ID_BITS-1:0] shadow_ids [MAX_HOLDERS];
    int                 shadow_total;

    lock_result_t expected_results [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        shadow_total = 0;
    end

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        if (fail_count < PRINT_CAP)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
        fail_count++;
    endtask

    // Apply one request to the shadow table and return the result it should give
    function automatic lock_result_t apply_lock_request(input logic is_release,
                                                        input logic [ID_BITS-1:0] id);
        lock_result_t res;
        int           pos;
        int           i;
        pos = shadow_total;
        for (i = 0; i < shadow_total; i++)
            if (shadow_ids[i] == id && pos == shadow_total) pos = i;
        if (!is_release) begin
            // full wins over busy: a full table reports full even when the id is held
            if (shadow_total >= MAX_HOLDERS) begin
                res.status = bkt_lock_pkg::ST_FULL;
            end else if (pos < shadow_total) begin
                res.status = bkt_lock_pkg::ST_BUSY;
            end else begin
                shadow_ids[shadow_total] = id;
                shadow_total++;
                res.status = bkt_lock_pkg::ST_GRANTED;
            end
        end else if (pos >= shadow_total) begin
            res.status = bkt_lock_pkg::ST_UNHELD;
        end else begin
            // close the gap left by the removed id
            for (i = pos; i + 1 < shadow_total; i++)
                shadow_ids[i] = shadow_ids[i + 1];
            shadow_total--;
            res.status = bkt_lock_pkg::ST_RELEASED;
        end
        res.held_count = bkt_lock_pkg::COUNT_W'(shadow_total);
        return res;
    endfunction

    // Result side is checked first: a request accepted at this edge cannot answer at it
    always @(posedge aclk) begin
        lock_result_t want;
        if (!aresetn) begin
            shadow_total = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding, status", -1,
                                    int'(m_status));
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", int'(want.status), int'(m_status));
                    if (m_held_count !== want.held_count)
                        report_mismatch("held_count", int'(want.held_count),
                                        int'(m_held_count));
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_lock_request(s_mode, s_bucket_id));
        end
        pending = expected_results.size();
    end

endmodule

/* bench/bucket_lock_table_tb.sv */
// Top of the bucket lock table testbench: clock, reset, request and result-side stimulus, verdict
`timescale 1ns / 100ps
module bucket_lock_table_tb;

    localparam int   ID_BITS      = bkt_lock_pkg::ID_BITS_DEF;
    localparam int   MAX_HOLDERS  = bkt_lock_pkg::MAX_HOLDERS_DEF;
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   SEGMENTS     = 13;
    localparam int   SEG_ITEMS    = 150;
    localparam int   POOL_SIZE    = 20;
    localparam int   HOLD_AT_A    = 300;
    localparam int   HOLD_AT_B    = 1200;
    localparam int   HOLD_CYCLES  = 250;

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              s_valid     = 1'b0;
    logic                              s_mode      = MODE_ACQUIRE;
    logic [ID_BITS-1:0]                s_bucket_id = '0;
    logic                              m_ready     = 1'b0;
    logic                              s_ready;
    logic                              m_valid;
    logic [bkt_lock_pkg::STATUS_W-1:0] m_status;
    logic [bkt_lock_pkg::COUNT_W-1:0]  m_held_count;

    int fail_count;
    int pending;
    int cycles = 0;
    bit calm   = 1'b0;  // no random idling on either side while set

    always #4 aclk = ~aclk;

    bucket_lock_table #(
        .MAX_HOLDERS (MAX_HOLDERS),
        .ID_BITS     (ID_BITS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_bucket_id  (s_bucket_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_held_count (m_held_count)
    );

    bucket_lock_table_chk #(
        .MAX_HOLDERS (MAX_HOLDERS),
        .ID_BITS     (ID_BITS)
    ) CHK (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_bucket_id  (s_bucket_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_held_count (m_held_count),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL bucket_lock_table");
            $finish;
        end
    end

    // Offer one request beat after a random gap; valid stays up when the gap is zero
    task automatic send_lock_req(input logic mode, input logic [ID_BITS-1:0] id);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_bucket_id <= id;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Result side: random stalls, plus two long hold-offs that back the block up
    initial begin : result_sink
        int gap;
        int beats;
        beats = 0;
        forever begin
            if (beats == HOLD_AT_A || beats == HOLD_AT_B)
                gap = HOLD_CYCLES;
            else
                gap = calm ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
        end
    end

    initial begin : stimulus
        logic [ID_BITS-1:0] pool [POOL_SIZE];
        logic [ID_BITS-1:0] id;
        logic               mode;
        int                 acq_pct;
        int                 seg;
        int                 n;
        int                 k;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-table release, busy, fill to full, full beats busy, compaction
        send_lock_req(MODE_RELEASE, ID_BITS'(5));
        send_lock_req(MODE_ACQUIRE, '0);
        send_lock_req(MODE_ACQUIRE, '0);
        send_lock_req(MODE_ACQUIRE, '1);
        for (k = 1; k <= MAX_HOLDERS - 2; k++)
            send_lock_req(MODE_ACQUIRE, ID_BITS'(k * 68));
        send_lock_req(MODE_ACQUIRE, ID_BITS'(700));
        send_lock_req(MODE_ACQUIRE, '0);
        send_lock_req(MODE_RELEASE, ID_BITS'(476));
        send_lock_req(MODE_RELEASE, '0);
        send_lock_req(MODE_RELEASE, ID_BITS'(952));
        send_lock_req(MODE_RELEASE, ID_BITS'(476));
        send_lock_req(MODE_ACQUIRE, ID_BITS'(476));

        // Random: segments with their own acquire bias and a small id pool, so that
        // hits, full tables and drained tables all come up
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(0, 2))
                0: acq_pct = 20;
                1: acq_pct = 50;
                default: acq_pct = 80;
            endcase
            for (k = 0; k < POOL_SIZE; k++) begin
                case ($urandom_range(0, 7))
                    0: pool[k] = '0;
                    1: pool[k] = '1;
                    default: pool[k] = ID_BITS'($urandom_range(0, 1023));
                endcase
            end
            calm <= ($urandom_range(0, 4) == 0);
            for (n = 0; n < SEG_ITEMS; n++) begin
                mode = ($urandom_range(0, 99) < acq_pct) ? MODE_ACQUIRE : MODE_RELEASE;
                if ($urandom_range(0, 9) < 7)
                    id = pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    id = ID_BITS'($urandom_range(0, 1023));
                send_lock_req(mode, id);
            end
        end
        s_valid <= 1'b0;
        calm    <= 1'b0;

        // Drain, then allow time for any stray beat
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS bucket_lock_table");
        else
            $display("FAIL bucket_lock_table");
        $finish;
    end

endmodule
